FILE: hw/rtl/ppw_pkg.sv
`default_nettype none
package ppw_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int CW = COORD_WIDTH;
	localparam int HW_WIDTH = 12;
	localparam int SCALE_WIDTH = 16;
	localparam int CFG_DATA_WIDTH = (CW > 16) ? CW : 16;
	localparam int CFG_IDX_WIDTH = 3;
	// projected x in 2^-14 units: centre*2^14 plus (x-c)*s
	localparam int PX_WIDTH = CW + 19;
	localparam int DV_WIDTH = PX_WIDTH + 1;
	localparam int HWS_WIDTH = HW_WIDTH + SCALE_WIDTH;
	localparam int NORM_WIDTH = 31;
	localparam int SQ_WIDTH = 62;
	localparam int LEN_WIDTH = 31;
	localparam int PROD_WIDTH = NORM_WIDTH + HWS_WIDTH + 1;
	localparam int QW = PROD_WIDTH;
	localparam int QCNT_WIDTH = $clog2(QW + 1);
	localparam int SHIFT_WIDTH = $clog2(DV_WIDTH + 1);

	localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_WIDTH = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_CENTER_X = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR_Y = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_NEAR_Y = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_FAR_SCALE = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_NEAR_SCALE = 3'd5;

	// datapath operations, one per controller step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,       // latch a, b, c points
		OP_SC_A,       // start scale divide for point a
		OP_SC_A_END,
		OP_SC_B,
		OP_SC_B_END,
		OP_SC_C,
		OP_SC_C_END,
		OP_PROJ_A,     // multiply projections
		OP_PROJ_B,
		OP_PROJ_C,
		OP_CHORD,      // dx, dy, hw*s
		OP_NORM,       // normalise one step
		OP_SQ,         // square sum
		OP_SQRT,       // start root
		OP_PRODX,      // start offset divides
		OP_PRODY,
		OP_EDGE        // latch the final offset; the edges round from it combinationally
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel_last;  // second pass of a last word
		logic eop;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic sqrt_busy;
		logic norm_done;
		logic zero_chord;
	} stat_t;

	function automatic logic [CW-1:0] sat_coord(input logic signed [DV_WIDTH+1:0] v);
		logic signed [DV_WIDTH+1:0] hi;
		logic signed [DV_WIDTH+1:0] lo;
		hi = (DV_WIDTH+2)'((64'sd1 <<< (CW - 1)) - 64'sd1);
		lo = -hi - (DV_WIDTH+2)'(1);
		if (v > hi) return hi[CW-1:0];
		else if (v < lo) return lo[CW-1:0];
		else return v[CW-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/polyline_perspective_widen.sv
`default_nettype none
// polyline_perspective_widen: turns a stream of path points into stroke edge pairs
// input word: point_x, point_y, is_last on valid/ready; output word: left/right
// edge coordinates and end_of_path on valid/ready. configuration through
// cfg_we/cfg_idx/cfg_data while idle.
// the first point of a path gives no word and is taken while the block stays idle; each later
// point gives the edge pair of the point before it, and a last point gives its
// own pair too, running the whole pass a second time.
// a pass runs three scale divides (each only when the scale needs one), the
// chord normalisation shifts, the square root and two offset divides one
// after another through one shared bit-serial divider and one root unit; a
// zero chord skips from normalisation straight to the edge step.
// the input is held off while a word is in flight and until the output word
// is taken, so a stalled receiver stops the block without loss.
// reset clears the held points and loads the register defaults.
module polyline_perspective_widen import ppw_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [CW-1:0]      point_x,
	input  wire logic signed [CW-1:0]      point_y,
	input  wire logic                      is_last,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [CW-1:0]           left_x,
	output logic signed [CW-1:0]           left_y,
	output logic signed [CW-1:0]           right_x,
	output logic signed [CW-1:0]           right_y,
	output logic                           end_of_path
);
	cmd_t  cmd;
	stat_t stat;
	logic  shift_in, capture;
	logic signed [CW-1:0] hx_q, hy_q;

	ppw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_last(is_last),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .cmd(cmd), .shift_in(shift_in), .capture(capture)
	);

	// input word held while being processed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hx_q <= point_x;
			hy_q <= point_y;
		end
	end

	ppw_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_x((in_valid && in_ready) ? point_x : hx_q),
		.in_y((in_valid && in_ready) ? point_y : hy_q),
		.shift_in(shift_in), .capture(capture), .stat(stat),
		.o_lx(left_x), .o_ly(left_y), .o_rx(right_x), .o_ry(right_y), .o_eop(end_of_path)
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("output word dropped");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while word pending");
endmodule
`default_nettype wire

FILE: hw/rtl/ppw_div.sv
`default_nettype none
// restoring unsigned divider, one quotient bit per cycle, rounds to nearest
module ppw_div import ppw_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [QW-1:0] num,
	input  wire logic [QW-1:0] den,
	output logic               busy,
	output logic [QW-1:0]      quo
);
	logic [QW-1:0] rem_q, q_q, den_q, num_q;
	logic [QCNT_WIDTH-1:0] cnt_q;
	logic [QW:0] trial;
	logic [QW:0] rem_sh;
	logic        fin_q;

	always_comb begin
		rem_sh = {rem_q, num_q[QW-1]};
		trial = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= QCNT_WIDTH'(QW);
			fin_q <= 1'b0;
		end else if (busy) begin
			if (cnt_q == '0) begin
				busy <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// add den/2 for round to nearest
			num_q <= num + (den >> 1);
			den_q <= den;
			rem_q <= '0;
			q_q <= '0;
		end else if (busy && cnt_q != '0) begin
			num_q <= {num_q[QW-2:0], 1'b0};
			if (!trial[QW]) begin
				rem_q <= trial[QW-1:0];
				q_q <= {q_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[QW-1:0];
				q_q <= {q_q[QW-2:0], 1'b0};
			end
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

FILE: hw/rtl/ppw_sqrt.sv
`default_nettype none
// bitwise integer square root, one result bit per cycle
module ppw_sqrt import ppw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SQ_WIDTH-1:0]  val,
	output logic                      busy,
	output logic [LEN_WIDTH-1:0]      root
);
	logic [SQ_WIDTH-1:0] v_q, r_q, bit_q;
	logic [SQ_WIDTH-1:0] rb;

	assign rb = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
		end else if (start) begin
			busy <= 1'b1;
		end else if (busy && bit_q == '0) begin
			busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= val;
			r_q <= '0;
			bit_q <= SQ_WIDTH'(1) << (SQ_WIDTH - 2);
		end else if (busy && bit_q != '0) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
	assign root = r_q[LEN_WIDTH-1:0];
endmodule
`default_nettype wire

FILE: hw/rtl/ppw_datapath.sv
`default_nettype none
module ppw_datapath import ppw_pkg::*; (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_WIDTH-1:0]   cfg_idx,
	input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	input  wire logic signed [CW-1:0]       in_x,
	input  wire logic signed [CW-1:0]       in_y,
	input  wire logic                       shift_in, // new point enters history
	input  wire logic                       capture,  // first point fills both slots
	output stat_t                           stat,
	output logic signed [CW-1:0]            o_lx,
	output logic signed [CW-1:0]            o_ly,
	output logic signed [CW-1:0]            o_rx,
	output logic signed [CW-1:0]            o_ry,
	output logic                            o_eop
);
	logic [HW_WIDTH-1:0]    half_width_q;
	logic signed [CW-1:0]   center_x_q, far_y_q, near_y_q;
	logic [SCALE_WIDTH-1:0] far_scale_q, near_scale_q;
	logic signed [CW-1:0]   prev_x_q, prev_y_q, cur_x_q, cur_y_q;
	logic signed [CW-1:0]   ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [SCALE_WIDTH-1:0] sa_q, sb_q, sc_q;
	logic signed [PX_WIDTH-1:0] pa_q, pb_q, pc_q;
	logic signed [DV_WIDTH-1:0] dx_q, dy_q;
	logic [NORM_WIDTH-1:0]  ux_q, uy_q;
	logic [HWS_WIDTH-1:0]   hws_q;
	logic [SQ_WIDTH-1:0]    sq_q;
	logic signed [DV_WIDTH+1:0] ox_q, oy_q;
	logic                   sx_q, sy_q;
	logic [DV_WIDTH-1:0]    mx_q, my_q;
	logic [DV_WIDTH-1:0]    mm;

	// scale interpolation
	logic signed [CW:0]     den_s, num_s, den_a, num_a;
	logic signed [SCALE_WIDTH:0] sdiff;
	logic                   sc_far, sc_near;
	logic signed [CW-1:0]   y_sel;
	logic [QW-1:0]          div_num, div_den, div_quo;
	logic                   div_start, div_busy;
	logic                   sc_neg_q;
	logic [SCALE_WIDTH-1:0] sc_res;
	logic [SCALE_WIDTH:0]   sabs;
	logic [CW+SCALE_WIDTH:0] sprod;
	logic                   sq_start, sq_busy;
	logic [LEN_WIDTH-1:0]   len;
	logic [QW-1:0]          len_q;
	logic signed [CW:0]     xd;
	logic signed [PX_WIDTH-1:0] proj;
	logic signed [CW-1:0]   x_sel;
	logic [SCALE_WIDTH-1:0] s_sel;
	logic [QW-1:0]          pmag;
	logic signed [DV_WIDTH+1:0] ex_l, ey_l, ex_r, ey_r, pbx_e, pby_e;

	function automatic logic signed [DV_WIDTH+1:0] rnd14(input logic signed [DV_WIDTH+1:0] v);
		logic [DV_WIDTH+1:0] m;
		m = v[DV_WIDTH+1] ? -v : v;
		m = (m + (DV_WIDTH+2)'(8192)) >> 14;
		return v[DV_WIDTH+1] ? -m : m;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HW_WIDTH'(64);
			center_x_q <= '0;
			far_y_q <= '0;
			near_y_q <= CW'(4096);
			far_scale_q <= SCALE_WIDTH'(8192);
			near_scale_q <= SCALE_WIDTH'(16384);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_HALF_WIDTH: half_width_q <= cfg_data[HW_WIDTH-1:0];
				REG_CENTER_X:   center_x_q <= cfg_data[CW-1:0];
				REG_FAR_Y:      far_y_q <= cfg_data[CW-1:0];
				REG_NEAR_Y:     near_y_q <= cfg_data[CW-1:0];
				REG_FAR_SCALE:  far_scale_q <= cfg_data[SCALE_WIDTH-1:0];
				REG_NEAR_SCALE: near_scale_q <= cfg_data[SCALE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_SC_B, OP_SC_B_END: y_sel = by_q;
			OP_SC_C, OP_SC_C_END: y_sel = cy_q;
			default:              y_sel = ay_q;
		endcase
		den_s = near_y_q - far_y_q;
		num_s = y_sel - far_y_q;
		den_a = den_s[CW] ? -den_s : den_s;
		num_a = den_s[CW] ? -num_s : num_s;
		sc_far = (den_s == '0) || (num_a <= 0);
		sc_near = !sc_far && (num_a >= den_a);
		sdiff = $signed({1'b0, near_scale_q}) - $signed({1'b0, far_scale_q});
		sabs = sdiff[SCALE_WIDTH] ? -sdiff : sdiff;
		sprod = sabs * num_a[CW-1:0];
		if (sc_neg_q) sc_res = far_scale_q - div_quo[SCALE_WIDTH-1:0];
		else sc_res = far_scale_q + div_quo[SCALE_WIDTH-1:0];

		unique case (cmd.op)
			OP_PROJ_B: begin x_sel = bx_q; s_sel = sb_q; end
			OP_PROJ_C: begin x_sel = cx_q; s_sel = sc_q; end
			default:   begin x_sel = ax_q; s_sel = sa_q; end
		endcase
		xd = x_sel - center_x_q;
		proj = (PX_WIDTH'(center_x_q) <<< 14) + PX_WIDTH'(xd * $signed({1'b0, s_sel}));

		pmag = (cmd.op == OP_PRODX) ? QW'(uy_q) * QW'(hws_q) : QW'(ux_q) * QW'(hws_q);

		div_start = 1'b0;
		div_num = '0;
		div_den = QW'(1);
		unique case (cmd.op)
			OP_SC_A, OP_SC_B, OP_SC_C: begin
				div_start = !sc_far && !sc_near;
				div_num = QW'(sprod);
				div_den = QW'(den_a);
			end
			OP_PRODX, OP_PRODY: begin
				div_start = 1'b1;
				div_num = pmag;
				// the root is only latched on the first offset step
				div_den = (cmd.op == OP_PRODX) ? QW'(len) : len_q;
			end
			default: ;
		endcase
		sq_start = (cmd.op == OP_SQRT);
		mm = (mx_q > my_q) ? mx_q : my_q;

		pbx_e = (DV_WIDTH+2)'(pb_q);
		pby_e = (DV_WIDTH+2)'(by_q) <<< 14;
		ex_l = rnd14(pbx_e + ox_q);
		ey_l = rnd14(pby_e + oy_q);
		ex_r = rnd14(pbx_e - ox_q);
		ey_r = rnd14(pby_e - oy_q);
	end

	ppw_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo)
	);

	ppw_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(sq_q), .busy(sq_busy), .root(len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (capture) begin
			prev_x_q <= in_x;
			prev_y_q <= in_y;
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end else if (shift_in) begin
			prev_x_q <= cur_x_q;
			prev_y_q <= cur_y_q;
			cur_x_q <= in_x;
			cur_y_q <= in_y;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				if (cmd.sel_last) begin
					ax_q <= cur_x_q; ay_q <= cur_y_q;
					bx_q <= in_x;    by_q <= in_y;
				end else begin
					ax_q <= prev_x_q; ay_q <= prev_y_q;
					bx_q <= cur_x_q;  by_q <= cur_y_q;
				end
				cx_q <= in_x; cy_q <= in_y;
				o_eop <= cmd.eop;
			end
			OP_SC_A, OP_SC_B, OP_SC_C: begin
				sc_neg_q <= sdiff[SCALE_WIDTH];
				if (sc_far || sc_near) begin
					if (cmd.op == OP_SC_A) sa_q <= sc_far ? far_scale_q : near_scale_q;
					if (cmd.op == OP_SC_B) sb_q <= sc_far ? far_scale_q : near_scale_q;
					if (cmd.op == OP_SC_C) sc_q <= sc_far ? far_scale_q : near_scale_q;
				end
			end
			OP_SC_A_END: if (!sc_far && !sc_near) sa_q <= sc_res;
			OP_SC_B_END: if (!sc_far && !sc_near) sb_q <= sc_res;
			OP_SC_C_END: if (!sc_far && !sc_near) sc_q <= sc_res;
			OP_PROJ_A: pa_q <= proj;
			OP_PROJ_B: pb_q <= proj;
			OP_PROJ_C: pc_q <= proj;
			OP_CHORD: begin
				dx_q <= DV_WIDTH'(pc_q) - DV_WIDTH'(pa_q);
				dy_q <= (DV_WIDTH'(cy_q) - DV_WIDTH'(ay_q)) <<< 14;
				sx_q <= (DV_WIDTH'(pc_q) - DV_WIDTH'(pa_q)) < 0;
				sy_q <= cy_q < ay_q;
				hws_q <= half_width_q * sb_q;
				mx_q <= '0;
				my_q <= '0;
			end
			OP_NORM: begin
				if (mx_q == '0 && my_q == '0) begin
					mx_q <= sx_q ? DV_WIDTH'(-dx_q) : DV_WIDTH'(dx_q);
					my_q <= sy_q ? DV_WIDTH'(-dy_q) : DV_WIDTH'(dy_q);
				end else if (mm >= (DV_WIDTH'(1) << 30)) begin
					mx_q <= mx_q >> 1; my_q <= my_q >> 1;
				end else if (mm < (DV_WIDTH'(1) << 29)) begin
					mx_q <= mx_q << 1; my_q <= my_q << 1;
				end
			end
			OP_SQ: begin
				ux_q <= mx_q[NORM_WIDTH-1:0];
				uy_q <= my_q[NORM_WIDTH-1:0];
				sq_q <= SQ_WIDTH'(mx_q[NORM_WIDTH-1:0]) * SQ_WIDTH'(mx_q[NORM_WIDTH-1:0])
					+ SQ_WIDTH'(my_q[NORM_WIDTH-1:0]) * SQ_WIDTH'(my_q[NORM_WIDTH-1:0]);
			end
			OP_PRODX: len_q <= QW'(len);
			OP_PRODY: ox_q <= sy_q ? (DV_WIDTH+2)'(div_quo) : -(DV_WIDTH+2)'(div_quo);
			OP_EDGE: begin
				if (stat.zero_chord) begin
					ox_q <= '0;
					oy_q <= (DV_WIDTH+2)'(hws_q);
				end else begin
					oy_q <= sx_q ? -(DV_WIDTH+2)'(div_quo) : (DV_WIDTH+2)'(div_quo);
				end
			end
			default: ;
		endcase
	end

	// edge rounding straight from the offset registers
	assign o_lx = sat_coord(ex_l);
	assign o_ly = sat_coord(ey_l);
	assign o_rx = sat_coord(ex_r);
	assign o_ry = sat_coord(ey_r);

	assign stat.div_busy = div_busy;
	assign stat.sqrt_busy = sq_busy;
	assign stat.norm_done = (mm < (DV_WIDTH'(1) << 30)) && (mm >= (DV_WIDTH'(1) << 29));
	assign stat.zero_chord = (dx_q == '0) && (dy_q == '0);
endmodule
`default_nettype wire

FILE: hw/rtl/ppw_ctrl.sv
`default_nettype none
module ppw_ctrl import ppw_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire logic  in_last,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd,
	output logic       shift_in,
	output logic       capture
);
	typedef enum logic [4:0] {
		S_IDLE, S_LOAD, S_SCA, S_SCA_W, S_SCB, S_SCB_W, S_SCC, S_SCC_W,
		S_PA, S_PB, S_PC, S_CHORD, S_NORM0, S_NORM, S_SQ, S_SQRT, S_SQRT_W,
		S_PX, S_PX_W, S_PY, S_PY_W, S_EDGE, S_OUT
	} state_t;

	state_t state_q;
	logic [1:0] seen_q;
	logic last_q, pass2_q;

	always_comb begin
		cmd.sel_last = pass2_q;
		cmd.eop = pass2_q;
		unique case (state_q)
			S_LOAD:   cmd.op = OP_LOAD;
			S_SCA:    cmd.op = OP_SC_A;
			S_SCA_W:  cmd.op = stat.div_busy ? OP_NONE : OP_SC_A_END;
			S_SCB:    cmd.op = OP_SC_B;
			S_SCB_W:  cmd.op = stat.div_busy ? OP_NONE : OP_SC_B_END;
			S_SCC:    cmd.op = OP_SC_C;
			S_SCC_W:  cmd.op = stat.div_busy ? OP_NONE : OP_SC_C_END;
			S_PA:     cmd.op = OP_PROJ_A;
			S_PB:     cmd.op = OP_PROJ_B;
			S_PC:     cmd.op = OP_PROJ_C;
			S_CHORD:  cmd.op = OP_CHORD;
			S_NORM0, S_NORM: cmd.op = OP_NORM;
			S_SQ:     cmd.op = OP_SQ;
			S_SQRT:   cmd.op = OP_SQRT;
			S_PX:     cmd.op = stat.sqrt_busy ? OP_NONE : OP_PRODX;
			S_PY:     cmd.op = stat.div_busy ? OP_NONE : OP_PRODY;
			S_EDGE:   cmd.op = stat.div_busy ? OP_NONE : OP_EDGE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	// history moves on once the pair of a point that keeps the path open is taken
	assign shift_in = (state_q == S_OUT) && out_ready && !last_q;
	// a first point that does not end the path seeds both history slots
	assign capture = (state_q == S_IDLE) && in_valid && (seen_q == 2'd0) && !in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seen_q <= '0;
			last_q <= 1'b0;
			pass2_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					last_q <= in_last;
					pass2_q <= 1'b0;
					if (seen_q == 2'd0) begin
						seen_q <= in_last ? 2'd0 : 2'd1;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD:   state_q <= S_SCA;
				S_SCA:    state_q <= S_SCA_W;
				S_SCA_W:  if (!stat.div_busy) state_q <= S_SCB;
				S_SCB:    state_q <= S_SCB_W;
				S_SCB_W:  if (!stat.div_busy) state_q <= S_SCC;
				S_SCC:    state_q <= S_SCC_W;
				S_SCC_W:  if (!stat.div_busy) state_q <= S_PA;
				S_PA:     state_q <= S_PB;
				S_PB:     state_q <= S_PC;
				S_PC:     state_q <= S_CHORD;
				S_CHORD:  state_q <= S_NORM0;
				S_NORM0:  state_q <= stat.zero_chord ? S_EDGE : S_NORM;
				S_NORM:   state_q <= stat.norm_done ? S_SQ : S_NORM;
				S_SQ:     state_q <= S_SQRT;
				S_SQRT:   state_q <= S_PX;
				S_PX:     if (!stat.sqrt_busy) state_q <= S_PY;
				S_PY:     if (!stat.div_busy) state_q <= S_EDGE;
				S_EDGE:   if (!stat.div_busy) begin
					state_q <= S_OUT;
					out_valid <= 1'b1;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					if (last_q && !pass2_q) begin
						pass2_q <= 1'b1;
						state_q <= S_LOAD;
					end else begin
						state_q <= S_IDLE;
						seen_q <= last_q ? 2'd0 : 2'd2;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/polyline_perspective_widen_tb.sv
`default_nettype none
module polyline_perspective_widen_tb;
	import ppw_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 last;
	} point_t;

	typedef struct packed {
		logic signed [CW-1:0] lx;
		logic signed [CW-1:0] ly;
		logic signed [CW-1:0] rx;
		logic signed [CW-1:0] ry;
		logic                 eop;
	} edge_pair_t;

	localparam longint TIMEOUT_CYCLES = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_WIDTH-1:0] cfg_idx = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] point_x = '0;
	logic signed [CW-1:0] point_y = '0;
	logic is_last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] left_x, left_y, right_x, right_y;
	logic end_of_path;

	polyline_perspective_widen dut (.*);

	always #5 clk = ~clk;

	// predictor copy of the registers and held points
	longint m_hw, m_cx, m_fy, m_ny, m_fs, m_ns;
	longint h_px, h_py, h_cx, h_cy;
	int h_seen;

	point_t pending_points[$];
	edge_pair_t expected_pairs[$];
	int mismatches = 0;
	longint cycle_count = 0;
	bit drive_calm = 0;
	bit hold_sender = 0;
	int hold_receiver = 0;

	function automatic longint round_div(longint a, longint b);
		longint m, q;
		m = a < 0 ? -a : a;
		q = (m + b / 2) / b;
		return a < 0 ? -q : q;
	endfunction

	function automatic longint int_sqrt(longint v);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else
				r = r >> 1;
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] clamp_coord(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[CW-1:0];
	endfunction

	function automatic longint scale_for(longint y);
		longint den, num;
		den = m_ny - m_fy;
		num = y - m_fy;
		if (den == 0) return m_fs;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num <= 0) return m_fs;
		if (num >= den) return m_ns;
		return m_fs + round_div((m_ns - m_fs) * num, den);
	endfunction

	function automatic longint project_x(longint x, longint y);
		return m_cx * 16384 + (x - m_cx) * scale_for(y);
	endfunction

	function automatic edge_pair_t widen_point(longint ax, longint ay, longint bx,
			longint by, longint cx, longint cy, logic eop);
		longint dx, dy, pbx, pby, hw, ox, oy, ux, uy, mx, len, sdx, sdy;
		edge_pair_t r;
		dx = project_x(cx, cy) - project_x(ax, ay);
		dy = (cy - ay) * 16384;
		pbx = project_x(bx, by);
		pby = by * 16384;
		hw = m_hw * scale_for(by);
		if (dx == 0 && dy == 0) begin
			ox = 0;
			oy = hw;
		end else begin
			ux = dx < 0 ? -dx : dx;
			uy = dy < 0 ? -dy : dy;
			mx = ux > uy ? ux : uy;
			while (mx >= (64'sd1 << 30)) begin
				ux = ux >> 1; uy = uy >> 1; mx = mx >> 1;
			end
			while (mx < (64'sd1 << 29)) begin
				ux = ux << 1; uy = uy << 1; mx = mx << 1;
			end
			len = int_sqrt(ux * ux + uy * uy);
			sdx = dx < 0 ? -ux : ux;
			sdy = dy < 0 ? -uy : uy;
			ox = round_div(-sdy * hw, len);
			oy = round_div(sdx * hw, len);
		end
		r.lx = clamp_coord(round_div(pbx + ox, 16384));
		r.ly = clamp_coord(round_div(pby + oy, 16384));
		r.rx = clamp_coord(round_div(pbx - ox, 16384));
		r.ry = clamp_coord(round_div(pby - oy, 16384));
		r.eop = eop;
		return r;
	endfunction

	function automatic void predict_point(point_t p);
		longint px, py;
		px = p.x;
		py = p.y;
		if (h_seen == 0) begin
			if (!p.last) begin
				h_px = px; h_py = py; h_cx = px; h_cy = py;
				h_seen = 1;
			end
			return;
		end
		expected_pairs.push_back(widen_point(h_px, h_py, h_cx, h_cy, px, py, 1'b0));
		if (p.last) begin
			expected_pairs.push_back(widen_point(h_cx, h_cy, px, py, px, py, 1'b1));
			h_seen = 0;
		end else begin
			h_px = h_cx; h_py = h_cy; h_cx = px; h_cy = py;
			h_seen = 2;
		end
	endfunction

	// driver: the word on offer is always the head of the queue
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predict_point(pending_points.pop_front());
		end
		if (!(in_valid && !in_ready)) begin
			if (pending_points.size() > 0 && !hold_sender
					&& (drive_calm || $urandom_range(99) >= 29)) begin
				point_t nx;
				nx = pending_points[0];
				in_valid <= 1'b1;
				point_x <= nx.x;
				point_y <= nx.y;
				is_last <= nx.last;
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor and receiver
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (out_valid && out_ready) begin
			edge_pair_t got, want;
			got = '{left_x, left_y, right_x, right_y, end_of_path};
			if (expected_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %p", got);
			end else begin
				want = expected_pairs.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch expected %p actual %p", want, got);
				end
			end
		end
		if (hold_receiver > 0) begin
			hold_receiver <= hold_receiver - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= drive_calm || $urandom_range(99) >= 29;
	end

	task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val[CFG_DATA_WIDTH-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HALF_WIDTH: m_hw = val & 12'hFFF;
			REG_CENTER_X: m_cx = longint'($signed(val[15:0]));
			REG_FAR_Y: m_fy = longint'($signed(val[15:0]));
			REG_NEAR_Y: m_ny = longint'($signed(val[15:0]));
			REG_FAR_SCALE: m_fs = val & 16'hFFFF;
			default: m_ns = val & 16'hFFFF;
		endcase
	endtask

	task automatic drain_block();
		while (pending_points.size() != 0 || in_valid || expected_pairs.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic add_point(input int x, input int y, input bit last);
		point_t p;
		p.x = x[CW-1:0];
		p.y = y[CW-1:0];
		p.last = last;
		pending_points.push_back(p);
	endtask

	function automatic int rand_coord(int mode);
		case (mode)
			0: return $signed(16'($urandom));
			1: return $urandom_range(1, 0) ? 32767 - $urandom_range(40) : -32768 + $urandom_range(40);
			default: return $signed(16'($urandom)) / 8;
		endcase
	endfunction

	task automatic queue_random_paths(input int n);
		int left, len, mode, x, y;
		left = n;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
			mode = $urandom_range(9) < 2 ? $urandom_range(1) : 2;
			x = rand_coord(mode);
			y = rand_coord(mode);
			for (int i = 0; i < len && left > 0; i++) begin
				add_point(x, y, i == len - 1 || left == 1);
				left--;
				if ($urandom_range(7) != 0) begin
					x = x + $signed($urandom_range(800)) - 400;
					y = y + $signed($urandom_range(800)) - 400;
					if (x > 32767) x = 32767;
					if (x < -32768) x = -32768;
					if (y > 32767) y = 32767;
					if (y < -32768) y = -32768;
				end
			end
		end
	endtask

	initial begin
		m_hw = 64; m_cx = 0; m_fy = 0; m_ny = 4096; m_fs = 8192; m_ns = 16384;
		h_seen = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: lone point, zero chord, extremes, long stretch with no idling
		drive_calm = 1;
		add_point(100, 100, 1);
		add_point(0, 0, 0); add_point(0, 0, 0); add_point(0, 0, 1);
		add_point(32767, 32767, 0); add_point(-32768, -32768, 0);
		add_point(32767, -32768, 0); add_point(-32768, 32767, 1);
		add_point(10, 2000, 0); add_point(300, 5000, 0); add_point(-300, -100, 1);
		add_point(-1, -1, 0); add_point(1, 1, 1);
		drain_block();
		drive_calm = 0;

		write_reg(REG_HALF_WIDTH, 4095);
		write_reg(REG_CENTER_X, 32767);
		write_reg(REG_FAR_Y, 1000);
		write_reg(REG_NEAR_Y, 1000);
		write_reg(REG_FAR_SCALE, 65535);
		write_reg(REG_NEAR_SCALE, 0);
		add_point(-32768, 0, 0); add_point(32767, 999, 0); add_point(0, 1001, 0);
		add_point(5, -5, 1);
		drain_block();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_reg(REG_HALF_WIDTH, 0); write_reg(REG_CENTER_X, -32768);
					write_reg(REG_FAR_Y, 32767); write_reg(REG_NEAR_Y, -32768);
					write_reg(REG_FAR_SCALE, 0); write_reg(REG_NEAR_SCALE, 65535);
				end
				1: begin
					write_reg(REG_HALF_WIDTH, 64); write_reg(REG_CENTER_X, 0);
					write_reg(REG_FAR_Y, 0); write_reg(REG_NEAR_Y, 4096);
					write_reg(REG_FAR_SCALE, 8192); write_reg(REG_NEAR_SCALE, 16384);
				end
				default: begin
					write_reg(REG_HALF_WIDTH, $urandom_range(4095));
					write_reg(REG_CENTER_X, $urandom_range(65535));
					write_reg(REG_FAR_Y, $urandom_range(65535));
					write_reg(REG_NEAR_Y, $urandom_range(65535));
					write_reg(REG_FAR_SCALE, $urandom_range(65535));
					write_reg(REG_NEAR_SCALE, $urandom_range(65535));
				end
			endcase
			queue_random_paths(180);
			if (phase == 2) begin
				// long receiver stall so the block backs up onto its input
				hold_receiver = 3000;
				// then the sender waits for every word to come back
				wait (pending_points.size() < 90);
				hold_sender = 1;
				while (in_valid || expected_pairs.size() != 0) @(posedge clk);
				hold_sender = 0;
			end
			drain_block();
		end

		if (mismatches == 0)
			$display("polyline_perspective_widen_tb: clean");
		else
			$display("polyline_perspective_widen_tb: errors");
		$finish;
	end

	initial begin
		wait (cycle_count >= TIMEOUT_CYCLES);
		$display("polyline_perspective_widen_tb: errors");
		$finish;
	end
endmodule
`default_nettype wire
